// ===== hw/rtl/hsc_pkg.sv =====
// hsc_pkg: shared types and constants for the http header line scanner
// item structs, scan state codes, byte roles and error codes
// no dependencies
package hsc_pkg;

    // input item: one raw byte of the header section
    typedef struct packed {
        logic [7:0] data_byte;
        logic       new_request;
    } t_in_item;

    // result item: role of the byte and pair / error status
    typedef struct packed {
        logic [2:0] byte_role;
        logic       pair_done;
        logic [7:0] value_length;
        logic       headers_done;
        logic [2:0] error_code;
    } t_out_item;

    // scanner state carried from item to item
    typedef struct packed {
        logic [3:0] scan_state;
        logic [8:0] value_count;
        logic [2:0] sticky_error;
    } t_scan;

    // characters
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [8:0] COUNT_MAX = 9'd511;

    // scan states
    localparam logic [3:0] ST_START  = 4'd0;
    localparam logic [3:0] ST_KEY    = 4'd1;
    localparam logic [3:0] ST_COLON  = 4'd2;
    localparam logic [3:0] ST_SPACE  = 4'd3;
    localparam logic [3:0] ST_VALUE  = 4'd4;
    localparam logic [3:0] ST_CR     = 4'd5;
    localparam logic [3:0] ST_LF     = 4'd6;
    localparam logic [3:0] ST_END_CR = 4'd7;
    localparam logic [3:0] ST_BODY   = 4'd8;

    // byte roles
    localparam logic [2:0] ROLE_SKIP  = 3'd0;
    localparam logic [2:0] ROLE_KEY   = 3'd1;
    localparam logic [2:0] ROLE_SEP   = 3'd2;
    localparam logic [2:0] ROLE_VALUE = 3'd3;
    localparam logic [2:0] ROLE_EOL   = 3'd4;
    localparam logic [2:0] ROLE_FINAL = 3'd5;
    localparam logic [2:0] ROLE_BODY  = 3'd6;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_KEY_EOL   = 3'd1;
    localparam logic [2:0] ERR_NO_SPACE  = 3'd2;
    localparam logic [2:0] ERR_VALUE_LEN = 3'd3;
    localparam logic [2:0] ERR_CR_NO_LF  = 3'd4;

    // configuration register indexes
    localparam logic REG_MAX_VALUE_LENGTH = 1'b0;

    localparam logic [7:0] MAX_VALUE_LENGTH_RST = 8'd255;

endpackage

// ===== hw/rtl/hsc_step.sv =====
// hsc_step: next-state and result logic of the header scanner for one byte
// purely combinational, sits between the input and result registers
// depends on hsc_pkg
module hsc_step (
    input  hsc_pkg::t_scan     i_scan,
    input  hsc_pkg::t_in_item  i_item,
    input  logic [7:0]         i_max_value_length,
    output hsc_pkg::t_scan     o_scan,
    output hsc_pkg::t_out_item o_item
);
    import hsc_pkg::*;

    t_scan      cur;
    t_scan      nxt;
    logic [7:0] b;
    logic [2:0] role;
    logic       pair;
    logic [7:0] vlen;
    logic [2:0] err;

    assign b = i_item.data_byte;

    // new request restarts the scan before this byte
    always_comb begin
        cur = i_scan;
        if (i_item.new_request) begin
            cur.scan_state   = ST_START;
            cur.value_count  = '0;
            cur.sticky_error = ERR_NONE;
        end
    end

    // byte classification and state transition
    always_comb begin
        nxt  = cur;
        role = ROLE_SKIP;
        pair = 1'b0;
        vlen = '0;
        err  = ERR_NONE;
        if (cur.sticky_error == ERR_NONE) begin
            unique case (cur.scan_state)
                ST_KEY: begin
                    if (b == CH_COLON) begin
                        nxt.scan_state = ST_COLON;
                        role = ROLE_SEP;
                    end else if (b == CH_CR || b == CH_LF) begin
                        err = ERR_KEY_EOL;
                    end else begin
                        role = ROLE_KEY;
                    end
                end
                ST_COLON: begin
                    if (b == CH_SPACE) begin
                        nxt.scan_state = ST_SPACE;
                        role = ROLE_SEP;
                    end else begin
                        err = ERR_NO_SPACE;
                    end
                end
                ST_SPACE: begin
                    // first value byte is taken whatever it is
                    nxt.scan_state  = ST_VALUE;
                    nxt.value_count = 9'd1;
                    role = ROLE_VALUE;
                end
                ST_VALUE: begin
                    if (b == CH_CR) begin
                        if (cur.value_count > {1'b0, i_max_value_length}) begin
                            err = ERR_VALUE_LEN;
                        end else begin
                            nxt.scan_state = ST_CR;
                            role = ROLE_EOL;
                        end
                    end else begin
                        if (cur.value_count < COUNT_MAX) begin
                            nxt.value_count = cur.value_count + 9'd1;
                        end
                        role = ROLE_VALUE;
                    end
                end
                ST_CR: begin
                    if (b == CH_LF) begin
                        nxt.scan_state  = ST_LF;
                        nxt.value_count = '0;
                        role = ROLE_EOL;
                        pair = 1'b1;
                        vlen = cur.value_count[7:0];
                    end else begin
                        err = ERR_CR_NO_LF;
                    end
                end
                ST_LF: begin
                    if (b == CH_CR) begin
                        nxt.scan_state = ST_END_CR;
                        role = ROLE_FINAL;
                    end else begin
                        nxt.scan_state = ST_KEY;
                        role = ROLE_KEY;
                    end
                end
                ST_END_CR: begin
                    if (b == CH_LF) begin
                        nxt.scan_state = ST_BODY;
                        role = ROLE_FINAL;
                    end else begin
                        err = ERR_CR_NO_LF;
                    end
                end
                ST_BODY: begin
                    role = ROLE_BODY;
                end
                default: begin
                    // header start: skip leading line ends
                    if (b != CH_CR && b != CH_LF) begin
                        nxt.scan_state = ST_KEY;
                        role = ROLE_KEY;
                    end else begin
                        nxt.scan_state = ST_START;
                    end
                end
            endcase
            // a fresh error blanks this byte's result
            if (err != ERR_NONE) begin
                nxt.sticky_error = err;
                role = ROLE_SKIP;
                pair = 1'b0;
                vlen = '0;
            end
        end
    end

    // result item
    always_comb begin
        o_scan              = nxt;
        o_item.byte_role    = role;
        o_item.pair_done    = pair;
        o_item.value_length = vlen;
        o_item.headers_done = (nxt.sticky_error == ERR_NONE) && (nxt.scan_state == ST_BODY);
        o_item.error_code   = nxt.sticky_error;
    end

endmodule

// ===== hw/rtl/http_header_line_scanner_core.sv =====
// http_header_line_scanner_core: byte-wise http header section scanner
// an accepted item passes the input register, then the result register, before its result is valid
// throughput: one item per cycle unless the result stalls; state update is one pass through hsc_step
// a stalled result holds the item in the input register; the input stalls once that register is full
// reset: synchronous active low; scan restarts at header start, max_value_length returns to 255
// depends on hsc_pkg and hsc_step
module http_header_line_scanner_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    input  hsc_pkg::t_in_item  i_in_item,
    output logic               o_in_stall,
    // result channel
    output logic               o_out_valid,
    output hsc_pkg::t_out_item o_out_item,
    input  logic               i_out_stall,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import hsc_pkg::*;

    logic       r_in_valid;
    t_in_item   r_in_item;
    logic       r_out_valid;
    t_out_item  r_out_item;
    t_scan      r_scan;
    t_scan      n_scan;
    t_out_item  n_out_item;
    logic [7:0] r_max_value_length;
    logic       in_accept;
    logic       advance;
    logic       cfg_write;

    // handshake control
    assign advance   = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept = i_in_valid && !o_in_stall;

    // configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_MAX_VALUE_LENGTH);
    assign prdata    = (paddr[2] == REG_MAX_VALUE_LENGTH) ? {24'd0, r_max_value_length} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_value_length <= MAX_VALUE_LENGTH_RST;
        end else if (cfg_write) begin
            r_max_value_length <= pwdata[7:0];
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item <= i_in_item;
        end
    end

    // per-byte scan logic
    hsc_step u_step (
        .i_scan             (r_scan),
        .i_item             (r_in_item),
        .i_max_value_length (r_max_value_length),
        .o_scan             (n_scan),
        .o_item             (n_out_item)
    );

    // scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan.scan_state   <= ST_START;
            r_scan.value_count  <= '0;
            r_scan.sticky_error <= ERR_NONE;
        end else if (advance) begin
            r_scan <= n_scan;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
